[src/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define VPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define VPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vps_pkg.sv]
// shared types and constants of the velocity pid controller with drive smoothing
// no dependencies; imported by the top level
package vps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MUL_A_W    = 18;   // signed operand of the shared multiplier
    localparam int MUL_B_W    = 16;   // unsigned operand (gain or scale)
    localparam int MUL_W      = 35;
    localparam int ERR_W      = 36;
    localparam int ERRC_W     = 17;   // clamped error
    localparam int ROUND_HALF = 32768;
    localparam int FRAC_ONE   = 65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_MP,
        S_MI,
        S_MDL,
        S_MDH,
        S_ACC,
        S_CLAMP,
        S_DELTA,
        S_SCALE,
        S_NEW,
        S_FINISH
    } t_state;

endpackage

[src/vps_if.sv]
// valid/ready channel interfaces for the sample input and the drive result
// depends on nothing; used by the top level
interface vps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_us;
    logic [31:0] position;

    modport source (output valid, output now_us, output position, input ready);
    modport sink   (input valid, input now_us, input position, output ready);
endinterface

interface vps_out_if #(
    parameter int DAC_BITS = 16
);
    logic                valid;
    logic                ready;
    logic                updated;
    logic [DAC_BITS-1:0] dac_code;
    logic                significant_change;

    modport source (output valid, output updated, output dac_code,
                    output significant_change, input ready);
    modport sink   (input valid, input updated, input dac_code,
                    input significant_change, output ready);
endinterface

[src/velocity_pid_with_slew_filter_unit.sv]
// velocity-form pid position controller with a smoothed, clamped drive output
// depends on vps_pkg and the channel interfaces in vps_if.sv
//
// usage:
//   i_smp carries one sample beat: now_us timestamp and encoder position.
//   o_res returns one result beat per sample: updated flag, dac_code and
//   significant_change. configuration is written through i_cfg_we/idx/data
//   and the user must write it only while the block is idle; the block
//   itself does not enforce this.
// timing:
//   a sample that is due runs through one shared 18x16 multiplier and one
//   accumulator under a sequencer: the multiplier steps (target scale,
//   then p, i and two halves of d), then the clamp and smoothing stages.
//   a sample that arrives before the period has elapsed skips to the last
//   step. i_smp.ready is high only while the sequencer is idle, so a new
//   sample is taken only after the previous one has left the sequencer.
// reset: synchronous, active low; configuration registers return to their
//   defaults and the controller state (drive, history, last sample time) clears to zero.
// stall: the result sits in an output register; a new input beat is taken
//   while it waits, and that item holds in its last step until the slot frees.
module velocity_pid_with_slew_filter_unit
    import vps_pkg::*;
#(
    parameter int DAC_BITS      = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vps_in_if.sink                i_smp,
    vps_out_if.source             o_res
);

    localparam int DRV_W = DAC_BITS + FRAC_BITS;
    localparam int D2_W  = POSITION_BITS + 2;
    localparam int ACC_W = D2_W + 28;
    localparam int DLT_W = DRV_W + 1;
    localparam int SCL_W = DRV_W + 12;
    localparam int STP_W = SCL_W - FRAC_BITS;
    localparam int HI_W  = D2_W - 17;
    localparam logic [31:0] DAC_MASK = (32'd1 << DAC_BITS) - 32'd1;
    localparam logic signed [STP_W-1:0] STEP_HI = STP_W'(FRAC_ONE);
    localparam logic signed [STP_W-1:0] STEP_LO = -STEP_HI;

    // configuration registers
    logic signed [15:0] r_target;
    logic [15:0]        r_steps;
    logic [15:0]        r_err_lim;
    logic [15:0]        r_gain_p;
    logic [15:0]        r_gain_i;
    logic [15:0]        r_gain_d;
    logic [15:0]        r_drive_max;
    logic [31:0]        r_period;

    // controller state
    logic [31:0]                      r_last;
    logic signed [ERRC_W-1:0]         r_prev_err;
    logic signed [POSITION_BITS-1:0]  r_prev_pos;
    logic signed [POSITION_BITS-1:0]  r_older_pos;
    logic [DRV_W-1:0]                 r_drive;

    // working registers of one item
    t_state                           r_state, n_state;
    logic [31:0]                      r_now;
    logic signed [POSITION_BITS-1:0]  r_pos;
    logic signed [ERRC_W-1:0]         r_err;
    logic signed [D2_W-1:0]           r_d2;
    logic signed [MUL_W-1:0]          r_prod;
    logic signed [ACC_W-1:0]          r_acc;
    logic [DRV_W-1:0]                 r_clamped;
    logic signed [DLT_W-1:0]          r_delta;
    logic signed [SCL_W-1:0]          r_scaled;
    logic [DRV_W-1:0]                 r_nd;
    logic                             r_upd;
    logic                             r_flag;

    // output slot
    logic                r_out_valid;
    logic                r_out_upd;
    logic [DAC_BITS-1:0] r_out_code;
    logic                r_out_sig;

    logic                      in_fire;
    logic                      out_free;
    logic                      take;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [ERR_W-1:0]   err_full;
    logic signed [ERR_W-1:0]   err_lim;
    logic signed [ERRC_W-1:0]  err_clamped;
    logic signed [D2_W-1:0]    d2;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [DAC_BITS-1:0]       top_code;
    logic [DRV_W-1:0]          top;
    logic signed [ACC_W-1:0]   top_s;
    logic signed [STP_W-1:0]   step;

    assign in_fire  = i_smp.valid && i_smp.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign take     = !((r_now - r_last) < r_period);

    assign i_smp.ready              = (r_state == S_IDLE);
    assign o_res.valid              = r_out_valid;
    assign o_res.updated            = r_out_upd;
    assign o_res.dac_code           = r_out_code;
    assign o_res.significant_change = r_out_sig;

    // error against target, clamped symmetric
    always_comb begin
        err_full = ERR_W'(r_prod) - ERR_W'(r_pos);
        err_lim  = ERR_W'($signed({1'b0, r_err_lim}));
        if (err_full > err_lim) begin
            err_clamped = ERRC_W'(err_lim);
        end else if (err_full < -err_lim) begin
            err_clamped = ERRC_W'(-err_lim);
        end else begin
            err_clamped = ERRC_W'(err_full);
        end
        d2 = D2_W'(r_pos) - (D2_W'(r_prev_pos) <<< 1) + D2_W'(r_older_pos);
    end

    assign prod_ext = ACC_W'(r_prod);

    // drive ceiling is the smaller of drive_max and the dac range
    assign top_code = (32'(r_drive_max) > DAC_MASK) ? DAC_BITS'(DAC_MASK)
                                                    : DAC_BITS'(r_drive_max);
    assign top      = {top_code, {FRAC_BITS{1'b0}}};
    assign top_s    = ACC_W'(top);
    assign step     = STP_W'(r_scaled >>> FRAC_BITS);

    // sequencer: next state and shared multiplier operands
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_CHECK;
            end
            S_CHECK: begin
                mul_a   = MUL_A_W'(r_target);
                mul_b   = r_steps;
                n_state = take ? S_ERR : S_FINISH;
            end
            S_ERR: n_state = S_MP;
            S_MP: begin
                mul_a   = MUL_A_W'(r_err) - MUL_A_W'(r_prev_err);
                mul_b   = r_gain_p;
                n_state = S_MI;
            end
            S_MI: begin
                mul_a   = MUL_A_W'(r_err);
                mul_b   = r_gain_i;
                n_state = S_MDL;
            end
            S_MDL: begin
                // low 17 bits of the second difference, unsigned
                mul_a   = {1'b0, r_d2[16:0]};
                mul_b   = r_gain_d;
                n_state = S_MDH;
            end
            S_MDH: begin
                mul_a   = MUL_A_W'($signed(r_d2[D2_W-1 -: HI_W]));
                mul_b   = r_gain_d;
                n_state = S_ACC;
            end
            S_ACC:    n_state = S_CLAMP;
            S_CLAMP:  n_state = S_DELTA;
            S_DELTA:  n_state = S_SCALE;
            S_SCALE:  n_state = S_NEW;
            S_NEW:    n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 16'sd0;
            r_steps     <= 16'd1;
            r_err_lim   <= 16'd65535;
            r_gain_p    <= 16'd256;
            r_gain_i    <= 16'd0;
            r_gain_d    <= 16'd0;
            r_drive_max <= 16'd65535;
            r_period    <= 32'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET:    r_target    <= i_cfg_data[15:0];
                CFG_STEPS:     r_steps     <= i_cfg_data[15:0];
                CFG_ERR_LIMIT: r_err_lim   <= i_cfg_data[15:0];
                CFG_GAIN_P:    r_gain_p    <= i_cfg_data[15:0];
                CFG_GAIN_I:    r_gain_i    <= i_cfg_data[15:0];
                CFG_GAIN_D:    r_gain_d    <= i_cfg_data[15:0];
                CFG_DRIVE_MAX: r_drive_max <= i_cfg_data[15:0];
                CFG_PERIOD:    r_period    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // datapath of one item
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_now <= i_smp.now_us;
                    r_pos <= i_smp.position[POSITION_BITS-1:0];
                end
            end
            S_CHECK: begin
                r_upd  <= take;
                r_nd   <= r_drive;
                r_flag <= 1'b0;
            end
            S_ERR: begin
                r_err <= err_clamped;
                r_d2  <= d2;
            end
            S_MP:  r_acc <= ACC_W'({1'b0, r_drive});
            S_MI:  r_acc <= r_acc + (prod_ext <<< 8);
            S_MDL: r_acc <= r_acc + (prod_ext <<< 8);
            S_MDH: r_acc <= r_acc + (prod_ext <<< 8);
            // high half of the d product sits 17 bits up
            S_ACC: r_acc <= r_acc + (prod_ext <<< 25);
            S_CLAMP: begin
                if (r_acc[ACC_W-1]) begin
                    r_clamped <= '0;
                end else if (r_acc > top_s) begin
                    r_clamped <= top;
                end else begin
                    r_clamped <= r_acc[DRV_W-1:0];
                end
            end
            S_DELTA: r_delta <= DLT_W'({1'b0, r_clamped}) - DLT_W'({1'b0, r_drive});
            S_SCALE: begin
                // 1966 * delta by shift-add, plus half for round to nearest
                r_scaled <= (SCL_W'(r_delta) <<< 11) - (SCL_W'(r_delta) <<< 6)
                          - (SCL_W'(r_delta) <<< 4) - (SCL_W'(r_delta) <<< 1)
                          + SCL_W'(ROUND_HALF);
            end
            S_NEW: begin
                r_nd   <= r_drive + DRV_W'(step);
                r_flag <= (step > STEP_HI) || (step < STEP_LO);
            end
            S_FINISH: ;
            default:  ;
        endcase
    end

    // controller state commit and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_prev_err  <= '0;
            r_prev_pos  <= '0;
            r_older_pos <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
            if (r_upd) begin
                r_last      <= r_now;
                r_prev_err  <= r_err;
                r_older_pos <= r_prev_pos;
                r_prev_pos  <= r_pos;
                r_drive     <= r_nd;
            end
        end else if (r_out_valid && o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && out_free) begin
            r_out_upd  <= r_upd;
            r_out_code <= r_nd[DRV_W-1:FRAC_BITS];
            r_out_sig  <= r_flag;
        end
    end

endmodule

[src/vps_checker.sv]
// port-level checks of the velocity pid controller, bound to the top level
// depends on assert_macros.svh and velocity_pid_with_slew_filter_unit
`include "assert_macros.svh"

module vps_checker #(
    parameter int DAC_BITS = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_out_updated,
    input logic [DAC_BITS-1:0] i_out_code,
    input logic                i_out_sig
);

    // a waiting result beat holds its payload
    `VPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_code) && $stable(i_out_updated) && $stable(i_out_sig), "result beat changed while stalled")

    // one item at a time: the input closes after a beat
    `VPS_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken while busy")

    // no result can appear the cycle right after an input beat
    `VPS_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid), "result too early")

    // a skipped sample never reports a drive change
    `VPS_ASSERT_NOW(a_skip_flag, i_clk, i_rst_n, i_out_valid && !i_out_updated, !i_out_sig, "change flag without update")

endmodule

bind velocity_pid_with_slew_filter_unit vps_checker #(
    .DAC_BITS(DAC_BITS)
) u_vps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_updated(o_res.updated),
    .i_out_code   (o_res.dac_code),
    .i_out_sig    (o_res.significant_change)
);
